/* hdl/fbdl_pkg.sv */
// ----------------------------------------------------------------------------
// fbdl_pkg: shared types and codes for the five-button debounce latch
// Request codes, button mode codes, field widths and the per-button
// control bundle driven from the top level into every button cell.
// ----------------------------------------------------------------------------
package fbdl_pkg;

  localparam int REQ_W    = 3;
  localparam int PIN_W    = 5;
  localparam int IDX_W    = 3;
  localparam int FLAG_W   = 5;
  localparam int COUNT_W  = 16;
  localparam int MASK_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_BUTTONS_DEF = 5;

  typedef logic [REQ_W-1:0]   req_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [1:0]         mode_t;

  localparam req_t REQ_TICK      = 3'd0;
  localparam req_t REQ_CHECK_ONE = 3'd1;
  localparam req_t REQ_CHECK_ALL = 3'd2;
  localparam req_t REQ_ENABLE    = 3'd3;
  localparam req_t REQ_DISABLE   = 3'd4;

  localparam mode_t MODE_INACTIVE = 2'd0;
  localparam mode_t MODE_RELEASED = 2'd1;
  localparam mode_t MODE_PUSHED   = 2'd2;
  localparam mode_t MODE_HELD     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DETECT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK    = 2'd2;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    logic                  step;
    req_t                  req_type;
    logic [PIN_W-1:0]      pin_levels;
    logic [IDX_W-1:0]      button_index;
    count_t                detect_ticks;
    count_t                holdoff_ticks;
    logic                  mask_load;
    logic [MASK_W-1:0]     mask;
  } ctrl_t;

endpackage

/* hdl/fbdl_button.sv */
// ----------------------------------------------------------------------------
// fbdl_button: debounce state for one button
// Holds the mode and run count of one button and applies one transaction
// per step: tick sampling, check, enable or disable; a mask reload takes priority.
// ----------------------------------------------------------------------------
module fbdl_button #(
  parameter int BTN_IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  fbdl_pkg::ctrl_t ctrl,
  output logic           report
);

  localparam bit HAS_PIN  = (BTN_IDX < fbdl_pkg::PIN_W);
  localparam bit HAS_MASK = (BTN_IDX < fbdl_pkg::MASK_W);
  localparam bit HAS_IDX  = (BTN_IDX < (1 << fbdl_pkg::IDX_W));
  localparam logic [2:0] PIN_SEL  = HAS_PIN ? 3'(BTN_IDX) : 3'd0;
  localparam logic [2:0] MASK_SEL = HAS_MASK ? 3'(BTN_IDX) : 3'd0;
  localparam logic [fbdl_pkg::IDX_W-1:0] IDX_CODE = fbdl_pkg::IDX_W'(BTN_IDX);

  fbdl_pkg::mode_t  mode_r, mode_nxt;
  fbdl_pkg::count_t count_r, count_nxt;

  logic             pressed;
  logic             hit;
  fbdl_pkg::count_t bumped;
  fbdl_pkg::count_t run;

  assign pressed = HAS_PIN ? ~ctrl.pin_levels[PIN_SEL] : 1'b1;
  assign hit     = HAS_IDX && (ctrl.button_index == IDX_CODE);
  assign bumped  = (count_r == fbdl_pkg::COUNT_MAX) ? count_r
                                                    : count_r + fbdl_pkg::count_t'(1);

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    report    = 1'b0;
    run       = '0;
    if (ctrl.mask_load) begin
      mode_nxt  = (HAS_MASK && ctrl.mask[MASK_SEL]) ? fbdl_pkg::MODE_RELEASED
                                                    : fbdl_pkg::MODE_INACTIVE;
      count_nxt = '0;
    end else if (ctrl.step) begin
      unique case (ctrl.req_type)
        fbdl_pkg::REQ_TICK: begin
          if (mode_r == fbdl_pkg::MODE_RELEASED) begin
            run = pressed ? bumped : '0;
            if (run >= ctrl.detect_ticks) begin
              mode_nxt  = fbdl_pkg::MODE_PUSHED;
              count_nxt = '0;
            end else begin
              count_nxt = run;
            end
          end else if (mode_r != fbdl_pkg::MODE_INACTIVE) begin
            run = pressed ? '0 : bumped;
            if (run >= ctrl.holdoff_ticks) begin
              mode_nxt  = fbdl_pkg::MODE_RELEASED;
              count_nxt = '0;
            end else begin
              count_nxt = run;
            end
          end
        end
        fbdl_pkg::REQ_CHECK_ONE,
        fbdl_pkg::REQ_CHECK_ALL: begin
          if ((ctrl.req_type == fbdl_pkg::REQ_CHECK_ALL || hit) &&
              mode_r == fbdl_pkg::MODE_PUSHED) begin
            mode_nxt = fbdl_pkg::MODE_HELD;
            report   = 1'b1;
          end
        end
        fbdl_pkg::REQ_ENABLE: begin
          if (hit && mode_r == fbdl_pkg::MODE_INACTIVE) begin
            mode_nxt = fbdl_pkg::MODE_RELEASED;
          end
        end
        fbdl_pkg::REQ_DISABLE: begin
          if (hit) begin
            mode_nxt = fbdl_pkg::MODE_INACTIVE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= HAS_MASK ? fbdl_pkg::MODE_RELEASED : fbdl_pkg::MODE_INACTIVE;
      count_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* hdl/five_button_debounce_latch.sv */
// ----------------------------------------------------------------------------
// five_button_debounce_latch: debouncer and push latch for active-low buttons
// Tick, check, enable and disable transactions drive per-button debounce
// state; each transaction returns one pushed-flags result.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction. The result is
// offered once it has passed the input register and then the result register;
// a stalled result holds both registers. A new transaction is accepted every
// cycle while results are being taken. All buttons update in parallel within
// the single stage between those two registers. Configuration writes are
// accepted every cycle (cfg_ready is always high) and take effect at the
// accepting edge; a mask write reloads every button to released or inactive
// with its count cleared.
module five_button_debounce_latch #(
  parameter int NUM_BUTTONS = fbdl_pkg::NUM_BUTTONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fbdl_pkg::REQ_W-1:0]       in_req_type,
  input  logic [fbdl_pkg::PIN_W-1:0]       in_pin_levels,
  input  logic [fbdl_pkg::IDX_W-1:0]       in_button_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fbdl_pkg::FLAG_W-1:0]      out_pushed_flags,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbdl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbdl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                             in_v_r;
  fbdl_pkg::req_t                   req_r;
  logic [fbdl_pkg::PIN_W-1:0]       pins_r;
  logic [fbdl_pkg::IDX_W-1:0]       idx_r;
  logic                             out_v_r;
  logic [fbdl_pkg::FLAG_W-1:0]      flags_r, flags_nxt;
  fbdl_pkg::count_t                 detect_r, holdoff_r;
  logic                             advance;
  logic                             cfg_wr;
  fbdl_pkg::ctrl_t                  ctrl;
  logic [NUM_BUTTONS-1:0]           report;

  assign advance   = !out_v_r || out_ready;
  assign in_ready  = !in_v_r || advance;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign out_valid = out_v_r;
  assign out_pushed_flags = flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r  <= in_req_type;
      pins_r <= in_pin_levels;
      idx_r  <= in_button_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detect_r  <= fbdl_pkg::count_t'(1);
      holdoff_r <= fbdl_pkg::count_t'(1);
    end else if (cfg_wr) begin
      if (cfg_index == fbdl_pkg::CFG_DETECT) begin
        detect_r <= cfg_data;
      end
      if (cfg_index == fbdl_pkg::CFG_HOLDOFF) begin
        holdoff_r <= cfg_data;
      end
    end
  end

  always_comb begin
    ctrl.step          = in_v_r && advance;
    ctrl.req_type      = req_r;
    ctrl.pin_levels    = pins_r;
    ctrl.button_index  = idx_r;
    ctrl.detect_ticks  = detect_r;
    ctrl.holdoff_ticks = holdoff_r;
    ctrl.mask_load     = cfg_wr && (cfg_index == fbdl_pkg::CFG_MASK);
    ctrl.mask          = cfg_data[fbdl_pkg::MASK_W-1:0];
  end

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
    fbdl_button #(
      .BTN_IDX(g)
    ) u_btn (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .report(report[g])
    );
  end

  for (genvar f = 0; f < fbdl_pkg::FLAG_W; f++) begin : g_flag
    if (f < NUM_BUTTONS) begin : g_on
      assign flags_nxt[f] = report[f];
    end else begin : g_off
      assign flags_nxt[f] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      flags_r <= flags_nxt;
    end
  end

  a_flags_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && advance && req_r != fbdl_pkg::REQ_CHECK_ONE &&
     req_r != fbdl_pkg::REQ_CHECK_ALL) |=> (out_pushed_flags == '0))
    else $error("pushed flags set for a non-check transaction");

  a_check_one_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && advance && req_r == fbdl_pkg::REQ_CHECK_ONE) |=>
      $onehot0(out_pushed_flags))
    else $error("check-one reported more than one button");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_v_r && out_v_r && !out_ready))
    else $error("input stalled without a blocked result");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && advance) |=> out_v_r)
    else $error("processed transaction produced no result");

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for five_button_debounce_latch
// A directed table covers reset behavior, every request code, zero thresholds,
// lost unread pushes, mask reloads and ignored requests. Random phases follow
// with changing thresholds up to the maximum, masks and idling on both
// sides. Every result transaction is checked against an in-bench model of
// the per-button debounce state.
// ----------------------------------------------------------------------------
module tb_top;
  import fbdl_pkg::*;

  localparam int NUM_BTN     = NUM_BUTTONS_DEF;
  localparam int IDX_MAX     = (1 << IDX_W) - 1;
  localparam int LATENCY     = 2;
  localparam int QUIET_LIMIT = 5000;
  localparam int MAX_SHOWN   = 10;
  localparam int PHASE_ITEMS = 150;

  localparam req_t REQ_RSVD_LO = 3'd5;
  localparam req_t REQ_RSVD_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [FLAG_W-1:0]    FLAGS_NONE = '0;
  localparam logic [PIN_W-1:0]     PINS_DOWN  = '0;
  localparam logic [PIN_W-1:0]     PINS_UP    = '1;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    req_t                   req;
    logic [PIN_W-1:0]       pins;
    logic [IDX_W-1:0]       idx;
    logic                   fixed;
    logic [FLAG_W-1:0]      fixed_flags;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  req_t                   in_req_type = REQ_TICK;
  logic [PIN_W-1:0]       in_pin_levels = '0;
  logic [IDX_W-1:0]       in_button_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [FLAG_W-1:0]      out_pushed_flags;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  mode_t             btn_mode  [NUM_BTN];
  count_t            btn_count [NUM_BTN];
  count_t            detect_thr;
  count_t            holdoff_thr;
  logic [MASK_W-1:0] enable_mask;

  logic [FLAG_W-1:0] flags_due [$];
  dir_row_t          dir_rows [$];
  logic [FLAG_W-1:0] want;
  logic [PIN_W-1:0]  pin_hold = '1;
  int                stall_pct = 0;
  int                quiet = 0;
  int                n_err = 0;
  int                n_sent = 0;
  int                n_checked = 0;
  int                n_cfg = 0;

  five_button_debounce_latch u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_pin_levels    (in_pin_levels),
    .in_button_index  (in_button_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pushed_flags (out_pushed_flags),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---- debounce state model ----
  function automatic count_t count_up(count_t c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic void reload_mask(logic [MASK_W-1:0] m);
    enable_mask = m;
    for (int i = 0; i < NUM_BTN; i++) begin
      btn_mode[i]  = m[i] ? MODE_RELEASED : MODE_INACTIVE;
      btn_count[i] = '0;
    end
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_DETECT:  detect_thr = val;
      CFG_HOLDOFF: holdoff_thr = val;
      CFG_MASK:    reload_mask(val[MASK_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic logic [FLAG_W-1:0] take_push(int i);
    if (btn_mode[i] == MODE_PUSHED) begin
      btn_mode[i] = MODE_HELD;
      return FLAG_W'(1) << i;
    end
    return FLAGS_NONE;
  endfunction

  function automatic logic [FLAG_W-1:0] debounce_request(req_t req, logic [PIN_W-1:0] pins,
                                                         logic [IDX_W-1:0] idx);
    logic [FLAG_W-1:0] flags;
    logic              idx_ok;
    logic              pressed;
    flags  = FLAGS_NONE;
    idx_ok = (idx < NUM_BTN);
    case (req)
      REQ_TICK: begin
        for (int i = 0; i < NUM_BTN; i++) begin
          pressed = ~pins[i];
          if (btn_mode[i] == MODE_RELEASED) begin
            btn_count[i] = pressed ? count_up(btn_count[i]) : count_t'(0);
            if (btn_count[i] >= detect_thr) begin
              btn_mode[i]  = MODE_PUSHED;
              btn_count[i] = '0;
            end
          end else if (btn_mode[i] != MODE_INACTIVE) begin
            btn_count[i] = pressed ? count_t'(0) : count_up(btn_count[i]);
            if (btn_count[i] >= holdoff_thr) begin
              btn_mode[i]  = MODE_RELEASED;
              btn_count[i] = '0;
            end
          end
        end
      end
      REQ_CHECK_ONE: begin
        if (idx_ok) flags = take_push(int'(idx));
      end
      REQ_CHECK_ALL: begin
        for (int i = 0; i < NUM_BTN; i++) flags |= take_push(i);
      end
      REQ_ENABLE: begin
        if (idx_ok && btn_mode[idx] == MODE_INACTIVE) btn_mode[idx] = MODE_RELEASED;
      end
      REQ_DISABLE: begin
        if (idx_ok) btn_mode[idx] = MODE_INACTIVE;
      end
      default: ;
    endcase
    return flags;
  endfunction

  // ---- error reporting ----
  task automatic flag_error(string what);
    n_err++;
    if (n_err <= MAX_SHOWN) $display("ERROR: %s", what);
  endtask

  // ---- result checker and receiver ----
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (flags_due.size() == 0) begin
        flag_error($sformatf("result %b with no transaction pending", out_pushed_flags));
      end else begin
        want = flags_due.pop_front();
        if (out_pushed_flags !== want)
          flag_error($sformatf("result %0d: pushed_flags expected %b actual %b",
                               n_checked, want, out_pushed_flags));
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---- drivers ----
  task automatic send_item(req_t req, logic [PIN_W-1:0] pins, logic [IDX_W-1:0] idx,
                           logic fixed, logic [FLAG_W-1:0] fixed_flags);
    logic [FLAG_W-1:0] pred;
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_pin_levels   <= pins;
    in_button_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = debounce_request(req, pins, idx);
    flags_due.push_back(fixed ? fixed_flags : pred);
    n_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (flags_due.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic idle_gap(int pct);
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(9) == 0) return IDX_W'($urandom_range(NUM_BTN, IDX_MAX));
    return IDX_W'($urandom_range(0, NUM_BTN - 1));
  endfunction

  // Ticks follow slowly changing pin levels so that runs reach the thresholds.
  task automatic send_random();
    int                r;
    logic [PIN_W-1:0]  pins;
    for (int i = 0; i < PIN_W; i++)
      if ($urandom_range(99) < 15) pin_hold[i] = ~pin_hold[i];
    r    = $urandom_range(99);
    pins = PIN_W'($urandom);
    if (r < 60)
      send_item(REQ_TICK, ($urandom_range(9) == 0) ? pins : pin_hold, pick_index(), 1'b0,
                FLAGS_NONE);
    else if (r < 70) send_item(REQ_CHECK_ONE, pins, pick_index(), 1'b0, FLAGS_NONE);
    else if (r < 80) send_item(REQ_CHECK_ALL, pins, pick_index(), 1'b0, FLAGS_NONE);
    else if (r < 87) send_item(REQ_ENABLE, pins, pick_index(), 1'b0, FLAGS_NONE);
    else if (r < 94) send_item(REQ_DISABLE, pins, pick_index(), 1'b0, FLAGS_NONE);
    else
      send_item(req_t'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI)), pins, IDX_W'($urandom),
                1'b0, FLAGS_NONE);
  endtask

  task automatic run_phase(count_t det, count_t hold, logic [MASK_W-1:0] mask,
                           int idle_pct, int stall);
    logic [CFG_DATA_W-1:0] mval;
    settle();
    mval = CFG_DATA_W'($urandom);
    mval[MASK_W-1:0] = mask;
    write_reg(CFG_DETECT, det);
    write_reg(CFG_HOLDOFF, hold);
    write_reg(CFG_MASK, mval);
    stall_pct = stall;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (k == PHASE_ITEMS / 2) settle();
      send_random();
      idle_gap(idle_pct);
    end
  endtask

  // ---- directed table ----
  task automatic add_item(req_t req, logic [PIN_W-1:0] pins, logic [IDX_W-1:0] idx,
                          logic fixed, logic [FLAG_W-1:0] fixed_flags);
    dir_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.req = req;
    row.pins = pins;
    row.idx = idx;
    row.fixed = fixed;
    row.fixed_flags = fixed_flags;
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_rows.push_back(row);
  endtask

  initial begin
    add_item(REQ_CHECK_ALL, 5'h15, 3'd0, 1'b1, 5'b00000);
    add_item(REQ_TICK,      PINS_DOWN, 3'd0, 1'b1, 5'b00000);
    add_item(REQ_CHECK_ONE, PINS_UP, 3'd0, 1'b1, 5'b00001);
    add_item(REQ_CHECK_ALL, PINS_UP, 3'd3, 1'b1, 5'b11110);
    add_item(REQ_CHECK_ALL, PINS_DOWN, 3'd0, 1'b1, 5'b00000);
    add_item(REQ_CHECK_ONE, PINS_DOWN, 3'd5, 1'b1, 5'b00000);
    add_item(REQ_DISABLE,   PINS_DOWN, 3'd7, 1'b1, 5'b00000);
    add_item(REQ_RSVD_HI,   PINS_DOWN, 3'd2, 1'b1, 5'b00000);
    add_item(REQ_RSVD_LO,   PINS_UP, 3'd6, 1'b1, 5'b00000);
    add_item(REQ_TICK,      PINS_UP, 3'd0, 1'b0, FLAGS_NONE);
    add_item(REQ_DISABLE,   PINS_UP, 3'd2, 1'b1, 5'b00000);
    add_item(REQ_ENABLE,    PINS_UP, 3'd1, 1'b1, 5'b00000);
    add_item(REQ_TICK,      PINS_DOWN, 3'd4, 1'b0, FLAGS_NONE);
    add_item(REQ_ENABLE,    PINS_UP, 3'd2, 1'b0, FLAGS_NONE);
    add_item(REQ_TICK,      PINS_UP, 3'd0, 1'b0, FLAGS_NONE);
    add_item(REQ_CHECK_ALL, PINS_UP, 3'd0, 1'b0, FLAGS_NONE);
    add_cfg(CFG_DETECT, 16'h0000);
    add_cfg(CFG_HOLDOFF, 16'h0000);
    add_item(REQ_TICK,      PINS_UP, 3'd0, 1'b0, FLAGS_NONE);
    add_item(REQ_CHECK_ONE, PINS_UP, 3'd4, 1'b0, FLAGS_NONE);
    add_item(REQ_TICK,      PINS_DOWN, 3'd0, 1'b0, FLAGS_NONE);
    add_item(REQ_CHECK_ALL, 5'h0a, 3'd1, 1'b0, FLAGS_NONE);
    add_cfg(CFG_MASK, 16'hffe5);
    add_cfg(CFG_SPARE, 16'h5a5a);
    add_item(REQ_TICK,      PINS_DOWN, 3'd0, 1'b0, FLAGS_NONE);
    add_item(REQ_CHECK_ALL, PINS_UP, 3'd0, 1'b0, FLAGS_NONE);
  end

  // ---- main sequence ----
  initial begin
    detect_thr  = 16'd1;
    holdoff_thr = 16'd1;
    reload_mask('1);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        send_item(dir_rows[r].req, dir_rows[r].pins, dir_rows[r].idx,
                  dir_rows[r].fixed, dir_rows[r].fixed_flags);
      end
    end

    run_phase(16'd1, 16'd1, 5'h1f, 0, 0);
    run_phase(16'd3, 16'd2, MASK_W'($urandom), 80, 0);
    run_phase(16'd0, 16'd4, 5'h1f, 0, 80);
    run_phase(16'd5, 16'd0, MASK_W'($urandom), 31, 31);
    run_phase(16'd2, 16'd3, 5'h00, 0, 0);
    run_phase(count_t'($urandom_range(0, 7)), count_t'($urandom_range(0, 7)), 5'h1f, 80, 0);
    run_phase(COUNT_MAX, 16'd1, 5'h1f, 0, 80);
    run_phase(16'd4, COUNT_MAX, MASK_W'($urandom), 31, 31);

    settle();
    stall_pct = 0;
    repeat (LATENCY + 4) @(posedge clk);
    if (flags_due.size() != 0)
      flag_error($sformatf("%0d results never arrived", flags_due.size()));

    $display("Covered all request codes, ignored requests, zero and full-scale thresholds,");
    $display("mask reloads and idling on both sides: %0d transactions, %0d results,",
             n_sent, n_checked);
    $display("%0d cfg writes, %0d errors", n_cfg, n_err);
    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
